/* rtl/mqtt_prd_pkg.sv */
package mqtt_prd_pkg;

    // Front-to-back queue entry: one classified input item
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_fq_item;

    // One result item
    typedef struct packed {
        logic       packet_end;
        logic       frame_error;
        logic       cmd_dropped;
        logic       cmd_done;
        logic [7:0] data_byte;
        logic [1:0] byte_kind;
    } t_result;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_NAME    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    localparam logic [3:0] CFG_DELIVER = 4'd0;
    localparam logic [3:0] CFG_PLEN    = 4'd1;
    localparam logic [3:0] CFG_PA      = 4'd2;
    localparam logic [3:0] CFG_PB      = 4'd3;
    localparam logic [3:0] CFG_PC      = 4'd4;
    localparam logic [3:0] CFG_PD      = 4'd5;

endpackage

/* rtl/mqtt_prd_fifo.sv */
module mqtt_prd_fifo
    import mqtt_prd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr_valid,
    output logic     o_wr_ready,
    input  t_fq_item i_wr_item,
    output logic     o_rd_valid,
    input  logic     i_rd_ready,
    output t_fq_item o_rd_item
);
    // Two-entry queue, full throughput
    t_fq_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr_en, rd_en;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_item  = r_mem[r_rp];
    assign wr_en = i_wr_valid && o_wr_ready;
    assign rd_en = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) r_wp <= ~r_wp;
            if (rd_en) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wp] <= i_wr_item;
    end
endmodule

/* rtl/mqtt_prd_engine.sv */
module mqtt_prd_engine
    import mqtt_prd_pkg::*;
#(
    parameter int PREFIX_MAX_BYTES  = 32,
    parameter int LENGTH_MAX_GROUPS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_deliver_enable,
    input  logic [5:0]  i_prefix_len,
    input  logic [255:0] i_prefix,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_fq_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);
    typedef enum logic [2:0] {
        PH_IDLE, PH_LEN, PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_ID, PH_PAYLOAD, PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_pub, n_pub, r_hasid, n_hasid, r_match, n_match, r_idl, n_idl;
    logic [27:0] r_acc, n_acc, r_left, n_left, left_m1;
    logic [1:0]  r_grp, n_grp;
    logic [15:0] r_tlen, n_tlen, r_tidx, n_tidx, tidx_p1;
    logic [5:0]  eff_plen;
    logic [7:0]  b, pbyte;
    logic        go, goidle, body;
    t_result     n_res, r_res;
    logic        r_ov;

    assign o_ready  = !r_ov || i_ready;
    assign go       = i_valid && o_ready;
    assign o_valid  = r_ov;
    assign o_result = r_res;
    assign b        = i_item.rx_byte;
    assign eff_plen = (i_prefix_len > 6'(PREFIX_MAX_BYTES)) ? 6'(PREFIX_MAX_BYTES)
                                                           : i_prefix_len;
    assign pbyte    = i_prefix[{r_tidx[4:0], 3'b000} +: 8];
    assign left_m1  = r_left - 28'd1;
    assign tidx_p1  = r_tidx + 16'd1;

    always_comb begin
        n_phase = r_phase; n_pub = r_pub; n_hasid = r_hasid; n_match = r_match;
        n_idl = r_idl; n_acc = r_acc; n_left = r_left; n_grp = r_grp;
        n_tlen = r_tlen; n_tidx = r_tidx;
        n_res = '0; goidle = 1'b0; body = 1'b0;
        if (i_item.op == OP_ABORT) begin
            if (r_phase != PH_IDLE) begin
                n_res.cmd_dropped = r_match;
                goidle = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_pub   = (b & 8'hF0) == 8'h30;
                    n_hasid = ((b >> 1) & 8'h03) != 8'h00;
                    n_acc = '0; n_grp = '0; n_match = 1'b0;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_acc = r_acc + (28'(b[6:0]) << (7 * r_grp));
                    n_grp = r_grp + 2'd1;
                    if (b[7]) begin
                        if (32'(r_grp) + 1 >= LENGTH_MAX_GROUPS) begin
                            n_res.frame_error = 1'b1;
                            goidle = 1'b1;
                        end
                    end else begin
                        n_left = n_acc;
                        if (n_acc == '0) begin
                            n_res.packet_end = 1'b1;
                            goidle = 1'b1;
                        end else n_phase = r_pub ? PH_TLEN_HI : PH_SKIP;
                    end
                end
                PH_TLEN_HI: begin
                    body = 1'b1;
                    n_tlen = {b, 8'h00};
                    n_phase = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    body = 1'b1;
                    n_tlen = {r_tlen[15:8], b};
                    if (left_m1 < 28'(n_tlen)) n_phase = PH_SKIP;
                    else begin
                        n_match = i_deliver_enable && (n_tlen >= 16'(eff_plen));
                        n_tidx = '0;
                        if (n_tlen != '0) n_phase = PH_TOPIC;
                        else if (r_hasid) begin n_phase = PH_ID; n_idl = 1'b1; end
                        else n_phase = PH_PAYLOAD;
                    end
                end
                PH_TOPIC: begin
                    body = 1'b1;
                    if (r_tidx < 16'(eff_plen)) begin
                        if (pbyte != b) n_match = 1'b0;
                    end else if (r_match) begin
                        n_res.byte_kind = KIND_NAME;
                    end
                    n_tidx = tidx_p1;
                    if (tidx_p1 == r_tlen) begin
                        if (r_hasid) begin n_phase = PH_ID; n_idl = 1'b1; end
                        else n_phase = PH_PAYLOAD;
                    end
                end
                PH_ID: begin
                    body = 1'b1;
                    n_idl = 1'b0;
                    if (!r_idl) n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    body = 1'b1;
                    if (r_match) n_res.byte_kind = KIND_PAYLOAD;
                end
                PH_SKIP: body = 1'b1;
                default: ;
            endcase
            if (body) begin
                n_left = left_m1;
                if (left_m1 == '0) begin
                    n_res.packet_end = 1'b1;
                    n_res.cmd_done = n_match;
                    goidle = 1'b1;
                end
            end
        end
        if (n_res.byte_kind != KIND_NONE) n_res.data_byte = b;
        if (goidle) begin
            n_phase = PH_IDLE; n_pub = 1'b0; n_hasid = 1'b0; n_match = 1'b0;
            n_idl = 1'b0; n_acc = '0; n_left = '0; n_grp = '0; n_tlen = '0; n_tidx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_pub <= 1'b0; r_hasid <= 1'b0; r_match <= 1'b0;
            r_idl <= 1'b0; r_acc <= '0; r_left <= '0; r_grp <= '0;
            r_tlen <= '0; r_tidx <= '0; r_ov <= 1'b0; r_res <= '0;
        end else begin
            if (go) begin
                r_phase <= n_phase; r_pub <= n_pub; r_hasid <= n_hasid;
                r_match <= n_match; r_idl <= n_idl; r_acc <= n_acc; r_left <= n_left;
                r_grp <= n_grp; r_tlen <= n_tlen; r_tidx <= n_tidx;
                r_res <= n_res;
            end
            if (go) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end
endmodule

/* rtl/mqtt_publish_receive_deframer.sv */
// An item passes through the front queue and then the result register before its result appears.
// Throughput: one item per cycle while the output is not stalled; the byte parser handles one byte per clock.
// The 2-entry front queue and result register let either side stall independently.
// Reset (synchronous, i_rst_n low): parser idle, queue and output empty,
// configuration registers cleared.
module mqtt_publish_receive_deframer
    import mqtt_prd_pkg::*;
#(
    parameter int PREFIX_MAX_BYTES  = 32,
    parameter int LENGTH_MAX_GROUPS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // data_byte[7:0], cmd_done, cmd_dropped,
                                        // frame_error, packet_end, zero fill
    output logic [1:0]  m_axis_tuser    // byte_kind
);
    logic         r_deliver;
    logic [5:0]   r_plen;
    logic [255:0] r_prefix;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deliver <= 1'b0;
            r_plen    <= '0;
            r_prefix  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DELIVER: r_deliver <= i_cfg_data[0];
                CFG_PLEN:    r_plen <= i_cfg_data[5:0];
                CFG_PA:      r_prefix[63:0] <= i_cfg_data;
                CFG_PB:      r_prefix[127:64] <= i_cfg_data;
                CFG_PC:      r_prefix[191:128] <= i_cfg_data;
                CFG_PD:      r_prefix[255:192] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: accept and hold bytes in a short queue
    t_fq_item fin, fout;
    logic     f_valid, f_ready;
    t_result  res;

    assign fin.op      = s_axis_tuser;
    assign fin.rx_byte = s_axis_tdata;

    mqtt_prd_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(s_axis_tvalid), .o_wr_ready(s_axis_tready), .i_wr_item(fin),
        .o_rd_valid(f_valid), .i_rd_ready(f_ready), .o_rd_item(fout)
    );

    // Back: packet parser
    mqtt_prd_engine #(
        .PREFIX_MAX_BYTES(PREFIX_MAX_BYTES), .LENGTH_MAX_GROUPS(LENGTH_MAX_GROUPS)
    ) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_deliver_enable(r_deliver), .i_prefix_len(r_plen), .i_prefix(r_prefix),
        .i_valid(f_valid), .o_ready(f_ready), .i_item(fout),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(res)
    );

    assign m_axis_tdata = {4'b0000, res.packet_end, res.frame_error, res.cmd_dropped,
                           res.cmd_done, res.data_byte};
    assign m_axis_tuser = res.byte_kind;

    // A result never carries both a delivered byte and an error or drop
    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res.byte_kind != KIND_NONE) |-> !res.frame_error && !res.cmd_dropped)
        else $error("delivered byte with error");
    // cmd_done only on a packet end
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.cmd_done |-> res.packet_end)
        else $error("cmd_done without packet_end");
    // Stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output changed under stall");
endmodule
